/* rtl/core/joystick_axis_conditioner_macros.svh */
// Assertion macros for the joystick axis conditioner.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef JOYSTICK_AXIS_CONDITIONER_MACROS_SVH
`define JOYSTICK_AXIS_CONDITIONER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define JAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("joystick conditioner check failed");
// next-cycle implication
`define JAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("joystick conditioner check failed");
`else
`define JAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define JAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/jac_pkg.sv */
// Shared types and constants for the joystick axis conditioner.
// No dependencies; used by the interfaces, controller, datapath and top level.
package jac_pkg;

    // parameter defaults
    localparam int SAMPLE_BITS_DEF = 12;

    // output full scale, fixed to suit the output field width
    localparam int OUT_SPAN   = 1000;

    // fixed field widths
    localparam int CENTER_W   = 12;
    localparam int DEAD_W     = 10;
    localparam int THRESH_W   = 11;
    localparam int OUT_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd2;

    // register reset values
    localparam logic [CENTER_W-1:0] CENTER_RST = 12'd2048;
    localparam logic [DEAD_W-1:0]   DEAD_RST   = 10'd600;
    localparam logic [THRESH_W-1:0] THRESH_RST = 11'd100;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul;
        logic step;
        logic sign;
        logic fin;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_last;
    } t_stat;

endpackage

/* rtl/core/jac_if.sv */
// Request channels of the joystick axis conditioner: sample in, result out.
// Depends on jac_pkg for default widths.
interface jac_in_if #(
    parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] x_sample;
    logic                   x_read_ok;
    logic [SAMPLE_BITS-1:0] y_sample;
    logic                   y_read_ok;
    logic                   button_level;

    modport source (output valid, x_sample, x_read_ok, y_sample, y_read_ok, button_level,
                    input ready);
    modport sink   (input valid, x_sample, x_read_ok, y_sample, y_read_ok, button_level,
                    output ready);
endinterface

interface jac_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [jac_pkg::OUT_W-1:0]    x_axis;
    logic signed [jac_pkg::OUT_W-1:0]    y_axis;
    logic                                btn_down;
    logic                                press_event;

    modport source (output valid, x_axis, y_axis, btn_down, press_event,
                    input ready);
    modport sink   (input valid, x_axis, y_axis, btn_down, press_event,
                    output ready);
endinterface

/* rtl/core/jac_ctrl.sv */
// Sequencing controller for the joystick axis conditioner.
// Depends on jac_pkg (command/status structs) and the assertion macro header.
`include "joystick_axis_conditioner_macros.svh"

module jac_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output jac_pkg::t_cmd  o_cmd,
    input  jac_pkg::t_stat i_stat
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SGN  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_SGN;
                end
            end
            S_SGN: begin
                o_cmd.sign = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `JAC_ASSERT_IMP(a_fin_slot_free, i_clk, i_rst_n, o_cmd.fin, !r_out_valid || i_out_ready)
    `JAC_ASSERT_NXT(a_fin_sets_valid, i_clk, i_rst_n, o_cmd.fin, r_out_valid)
    `JAC_ASSERT_NXT(a_div_exit, i_clk, i_rst_n, o_cmd.step && i_stat.div_last, r_state == S_SGN)

endmodule

/* rtl/core/jac_dpath.sv */
// Datapath of the joystick axis conditioner: config registers, two axis lanes
// with shared-count restoring dividers, hold filter and result register. Uses jac_pkg.
module jac_dpath #(
    parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  jac_pkg::t_cmd                     i_cmd,
    output jac_pkg::t_stat                    o_stat,
    input  logic                              i_cfg_we,
    input  logic [jac_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [jac_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [SAMPLE_BITS-1:0]            i_x_sample,
    input  logic                              i_x_read_ok,
    input  logic [SAMPLE_BITS-1:0]            i_y_sample,
    input  logic                              i_y_read_ok,
    input  logic                              i_button_level,
    output logic signed [jac_pkg::OUT_W-1:0]  o_x_axis,
    output logic signed [jac_pkg::OUT_W-1:0]  o_y_axis,
    output logic                              o_btn_down,
    output logic                              o_press_event
);

    localparam int OUT_SPAN = jac_pkg::OUT_SPAN;
    localparam int CW     = jac_pkg::CENTER_W;
    localparam int RD_W   = (SAMPLE_BITS > CW) ? SAMPLE_BITS : CW;
    localparam int SPAN_W = $clog2(OUT_SPAN + 1);
    localparam int AXIS_W = SPAN_W + 1;
    localparam int PROD_W = RD_W + SPAN_W;
    localparam int DIV_W  = CW;
    localparam int CNT_W  = $clog2(PROD_W);
    localparam int DIF_W  = AXIS_W + 1;
    localparam int CMP_W  = (DIF_W > jac_pkg::THRESH_W) ? DIF_W : jac_pkg::THRESH_W;

    // configuration
    logic [CW-1:0]                  r_center;
    logic [jac_pkg::DEAD_W-1:0]     r_dead;
    logic [jac_pkg::THRESH_W-1:0]   r_thresh;

    // per-lane working registers (lane 0 = x, lane 1 = y)
    logic [RD_W-1:0]          r_mag   [2];
    logic                     r_neg   [2];
    logic [PROD_W-1:0]        r_num   [2];
    logic [DIV_W-1:0]         r_rem   [2];
    logic [PROD_W-1:0]        r_quo   [2];
    logic signed [AXIS_W-1:0] r_fresh [2];
    logic signed [AXIS_W-1:0] r_held  [2];
    logic [DIV_W-1:0]         r_div;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_btn;
    logic                     r_prev;

    logic signed [jac_pkg::OUT_W-1:0] r_out_x, r_out_y;
    logic                             r_out_pressed, r_out_event;

    // combinational lane signals
    logic [SAMPLE_BITS-1:0]   l_samp  [2];
    logic                     l_ok    [2];
    logic [RD_W-1:0]          l_read  [2];
    logic signed [RD_W:0]     l_cent  [2];
    logic signed [RD_W:0]     l_ncent [2];
    logic [RD_W-1:0]          l_abs   [2];
    logic                     l_dzone [2];
    logic [RD_W-1:0]          n_mag   [2];
    logic [PROD_W-1:0]        n_num   [2];
    logic [DIV_W:0]           l_rsh   [2];
    logic                     l_ge    [2];
    logic [DIV_W:0]           l_rsub  [2];
    logic [SPAN_W-1:0]        l_qc    [2];
    logic signed [AXIS_W-1:0] l_pos   [2];
    logic signed [AXIS_W-1:0] n_fresh [2];
    logic signed [DIF_W-1:0]  l_diff  [2];
    logic signed [DIF_W-1:0]  l_ndiff [2];
    logic [DIF_W-1:0]         l_adiff [2];
    logic signed [AXIS_W-1:0] n_held  [2];
    logic signed [31:0]       l_wide  [2];
    logic [CW:0]              l_dsub;
    logic [DIV_W-1:0]         n_div;
    logic                     l_pressed;

    always_comb begin
        l_samp[0] = i_x_sample;
        l_samp[1] = i_y_sample;
        l_ok[0]   = i_x_read_ok;
        l_ok[1]   = i_y_read_ok;
        for (int l = 0; l < 2; l++) begin
            // centre, then magnitude/sign with dead band applied
            l_read[l]  = l_ok[l] ? RD_W'(l_samp[l]) : RD_W'(r_center);
            l_cent[l]  = $signed({1'b0, l_read[l]}) - $signed({1'b0, RD_W'(r_center)});
            l_ncent[l] = -l_cent[l];
            l_abs[l]   = l_cent[l][RD_W] ? l_ncent[l][RD_W-1:0] : l_cent[l][RD_W-1:0];
            l_dzone[l] = l_abs[l] < RD_W'(r_dead);
            n_mag[l]   = l_dzone[l] ? '0 : l_abs[l];

            n_num[l]   = PROD_W'(r_mag[l]) * PROD_W'(OUT_SPAN);

            // one restoring division step
            l_rsh[l]   = {r_rem[l], r_num[l][PROD_W-1]};
            l_ge[l]    = l_rsh[l] >= {1'b0, r_div};
            l_rsub[l]  = l_ge[l] ? (l_rsh[l] - {1'b0, r_div}) : l_rsh[l];

            // clamp and sign
            l_qc[l]    = (r_quo[l] > PROD_W'(OUT_SPAN)) ? SPAN_W'(OUT_SPAN)
                                                        : r_quo[l][SPAN_W-1:0];
            l_pos[l]   = $signed({1'b0, l_qc[l]});
            n_fresh[l] = r_neg[l] ? -l_pos[l] : l_pos[l];

            // hold filter: update only on a change above the threshold
            l_diff[l]  = DIF_W'(r_fresh[l]) - DIF_W'(r_held[l]);
            l_ndiff[l] = -l_diff[l];
            l_adiff[l] = l_diff[l][DIF_W-1] ? $unsigned(l_ndiff[l]) : $unsigned(l_diff[l]);
            n_held[l]  = (CMP_W'(l_adiff[l]) > CMP_W'(r_thresh)) ? r_fresh[l] : r_held[l];
            l_wide[l]  = 32'(n_held[l]);
        end
        // divisor not positive is taken as one
        l_dsub = {1'b0, r_center} - (CW + 1)'(r_dead);
        n_div  = (l_dsub[CW] || (l_dsub == '0)) ? DIV_W'(1) : l_dsub[CW-1:0];
        l_pressed = ~r_btn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= jac_pkg::CENTER_RST;
            r_dead   <= jac_pkg::DEAD_RST;
            r_thresh <= jac_pkg::THRESH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                jac_pkg::REG_CENTER: r_center <= i_cfg_data[CW-1:0];
                jac_pkg::REG_DEAD:   r_dead   <= i_cfg_data[jac_pkg::DEAD_W-1:0];
                jac_pkg::REG_THRESH: r_thresh <= i_cfg_data[jac_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held[0] <= '0;
            r_held[1] <= '0;
            r_prev    <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (i_cmd.mul) begin
                r_cnt <= '0;
            end else if (i_cmd.step) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.fin) begin
                r_held[0] <= n_held[0];
                r_held[1] <= n_held[1];
                r_prev    <= l_pressed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_div <= n_div;
            r_btn <= i_button_level;
        end
        for (int l = 0; l < 2; l++) begin
            if (i_cmd.load) begin
                r_mag[l] <= n_mag[l];
                r_neg[l] <= l_cent[l][RD_W];
            end
            if (i_cmd.mul) begin
                r_num[l] <= n_num[l];
                r_rem[l] <= '0;
                r_quo[l] <= '0;
            end else if (i_cmd.step) begin
                r_num[l] <= {r_num[l][PROD_W-2:0], 1'b0};
                r_rem[l] <= l_rsub[l][DIV_W-1:0];
                r_quo[l] <= {r_quo[l][PROD_W-2:0], l_ge[l]};
            end
            if (i_cmd.sign) begin
                r_fresh[l] <= n_fresh[l];
            end
        end
        if (i_cmd.fin) begin
            r_out_x       <= l_wide[0][jac_pkg::OUT_W-1:0];
            r_out_y       <= l_wide[1][jac_pkg::OUT_W-1:0];
            r_out_pressed <= l_pressed;
            r_out_event   <= l_pressed & ~r_prev;
        end
    end

    assign o_stat.div_last  = (r_cnt == CNT_W'(PROD_W - 1));
    assign o_x_axis         = r_out_x;
    assign o_y_axis         = r_out_y;
    assign o_btn_down       = r_out_pressed;
    assign o_press_event    = r_out_event;

endmodule

/* rtl/core/joystick_axis_conditioner.sv */
// Top level of the joystick axis conditioner; uses jac_pkg, jac_if, jac_ctrl, jac_dpath.
// A sample is taken in S_IDLE and passes through S_MUL, S_DIV, S_SGN and S_FIN; the dividers
// yield PROD_W = max(SAMPLE_BITS, 12) + clog2(OUT_SPAN + 1) quotient bits.
// The bit-a-cycle dividers run side by side on both axes, and a new sample is taken only once
// the controller is back in S_IDLE; a result left in the output register holds the next one.
// Reset: synchronous, active low; registers to 2048/600/100, held axes to zero.
module joystick_axis_conditioner #(
    parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    jac_in_if.sink                         i_samp,
    jac_out_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [jac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [jac_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    jac_pkg::t_cmd  cmd;
    jac_pkg::t_stat stat;
    logic           in_ready;
    logic           out_valid;

    jac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_samp.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    jac_dpath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_x_sample       (i_samp.x_sample),
        .i_x_read_ok      (i_samp.x_read_ok),
        .i_y_sample       (i_samp.y_sample),
        .i_y_read_ok      (i_samp.y_read_ok),
        .i_button_level   (i_samp.button_level),
        .o_x_axis         (o_res.x_axis),
        .o_y_axis         (o_res.y_axis),
        .o_btn_down       (o_res.btn_down),
        .o_press_event    (o_res.press_event)
    );

    assign i_samp.ready = in_ready;
    assign o_res.valid  = out_valid;

endmodule

/* sim/testbench.sv */
// Self-checking bench for joystick_axis_conditioner: directed table, then randomised phases.
// Needs jac_pkg, jac_in_if/jac_out_if and the RTL; predicts every result in-line.
module testbench;
    import jac_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;   // unmapped index, must be ignored
    localparam int QUIET_LIMIT     = 4000;
    localparam int SHOWN_FAULTS    = 50;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 244;
    localparam int TAIL_CYCLES     = 40;

    typedef struct packed {
        logic [SAMPLE_BITS_DEF-1:0] x;
        logic                       x_ok;
        logic [SAMPLE_BITS_DEF-1:0] y;
        logic                       y_ok;
        logic                       btn_level;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic                    pressed;
        logic                    press_ev;
    } report_t;

    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        sample_t               s;
        bit                    typed;
        report_t               r;
    } step_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    jac_in_if  samp ();
    jac_out_if res ();

    joystick_axis_conditioner DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_samp     (samp),
        .o_res      (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the block's registers and state
    logic [CENTER_W-1:0]     centre_cfg  = CENTER_RST;
    logic [DEAD_W-1:0]       dead_cfg    = DEAD_RST;
    logic [THRESH_W-1:0]     thresh_cfg  = THRESH_RST;
    logic signed [OUT_W-1:0] held_x      = '0;
    logic signed [OUT_W-1:0] held_y      = '0;
    logic                    was_pressed = 1'b0;

    report_t reports_due[$];
    int      faults       = 0;
    int      quiet_cycles = 0;
    logic    typed_due;
    report_t typed_rpt;

    logic        take_report = 1'b0;
    logic [15:0] stall_map   = 16'hFFFF;
    logic [7:0]  stall_phase = '0;
    int          burst_left  = 0;
    bit          gaps_on     = 1'b1;

    assign res.ready = take_report;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [OUT_W-1:0] scale_reading(
        logic [SAMPLE_BITS_DEF-1:0] raw, logic ok);
        longint mid, dz, reading, centred, divisor, scaled;
        mid     = longint'(centre_cfg);
        dz      = longint'(dead_cfg);
        reading = ok ? longint'(raw) : mid;
        centred = reading - mid;
        if (centred > -dz && centred < dz)
            centred = 0;
        divisor = mid - dz;
        if (divisor < 1)
            divisor = 1;
        scaled = centred * OUT_SPAN / divisor;   // truncates toward zero
        if (scaled > longint'(OUT_SPAN))
            scaled = OUT_SPAN;
        if (scaled < -longint'(OUT_SPAN))
            scaled = -OUT_SPAN;
        return scaled[OUT_W-1:0];
    endfunction

    // hysteresis: a change equal to the threshold keeps the old value
    function automatic logic signed [OUT_W-1:0] settle(
        logic signed [OUT_W-1:0] held, logic signed [OUT_W-1:0] fresh);
        int gap;
        gap = int'(fresh) - int'(held);
        if (gap < 0)
            gap = -gap;
        return (gap > int'(thresh_cfg)) ? fresh : held;
    endfunction

    function automatic report_t condition_sample(sample_t s);
        report_t r;
        logic    pressed;
        pressed    = ~s.btn_level;
        r.press_ev = pressed & ~was_pressed;
        held_x     = settle(held_x, scale_reading(s.x, s.x_ok));
        held_y     = settle(held_y, scale_reading(s.y, s.y_ok));
        was_pressed = pressed;
        r.x        = held_x;
        r.y        = held_y;
        r.pressed  = pressed;
        return r;
    endfunction

    // receiver: stall pattern re-drawn each time stall_phase wraps, sometimes never stalling
    always @(posedge i_clk) begin
        if (stall_phase == 8'hFF)
            stall_map <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0001;
        take_report <= stall_map[stall_phase[3:0]];
        stall_phase <= stall_phase + 8'd1;
    end

    always @(posedge i_clk) begin
        report_t got;
        report_t want;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                moved = 1'b1;
                case (i_cfg_idx)
                    REG_CENTER: centre_cfg = i_cfg_data[CENTER_W-1:0];
                    REG_DEAD:   dead_cfg   = i_cfg_data[DEAD_W-1:0];
                    REG_THRESH: thresh_cfg = i_cfg_data[THRESH_W-1:0];
                    default: ;
                endcase
            end
            if (samp.valid && samp.ready) begin
                moved = 1'b1;
                want = condition_sample('{samp.x_sample, samp.x_read_ok, samp.y_sample,
                                          samp.y_read_ok, samp.button_level});
                if (typed_due)
                    want = typed_rpt;
                reports_due.push_back(want);
            end
            if (res.valid && res.ready) begin
                moved = 1'b1;
                got = '{res.x_axis, res.y_axis, res.btn_down, res.press_event};
                if (reports_due.size() == 0) begin
                    faults++;
                    if (faults <= SHOWN_FAULTS)
                        $display("%0t: request out with none due: x=%0d y=%0d pressed=%0b event=%0b",
                                 $time, got.x, got.y, got.pressed, got.press_ev);
                end else begin
                    want = reports_due.pop_front();
                    if (got.x !== want.x || got.y !== want.y ||
                        got.pressed !== want.pressed || got.press_ev !== want.press_ev) begin
                        faults++;
                        if (faults <= SHOWN_FAULTS)
                            $display("%0t: expected x=%0d y=%0d pressed=%0b event=%0b, got x=%0d y=%0d pressed=%0b event=%0b",
                                     $time, want.x, want.y, want.pressed, want.press_ev,
                                     got.x, got.y, got.pressed, got.press_ev);
                    end
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic step_row_t sample_row(int x, bit x_ok, int y, bit y_ok, bit btn);
        step_row_t row;
        row       = '{default: '0};
        row.s     = '{x[SAMPLE_BITS_DEF-1:0], x_ok, y[SAMPLE_BITS_DEF-1:0], y_ok, btn};
        return row;
    endfunction

    function automatic step_row_t checked_row(int x, bit x_ok, int y, bit y_ok, bit btn,
                                              int ex, int ey, bit ep, bit ee);
        step_row_t row;
        row       = sample_row(x, x_ok, y, y_ok, btn);
        row.typed = 1'b1;
        row.r     = '{ex[OUT_W-1:0], ey[OUT_W-1:0], ep, ee};
        return row;
    endfunction

    function automatic step_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        step_row_t row;
        row        = '{default: '0};
        row.is_reg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        return row;
    endfunction

    function automatic logic [SAMPLE_BITS_DEF-1:0] pick_reading();
        int v;
        case ($urandom_range(0, 3))
            0: v = int'($urandom_range(0, 4095));
            1: v = int'(centre_cfg) + ($urandom_range(0, 1) ? 1 : -1) *
                   (int'(dead_cfg) + int'($urandom_range(0, 4)) - 2);   // dead band edges
            2: v = $urandom_range(0, 1) ? int'($urandom_range(0, 3))
                                        : int'($urandom_range(4092, 4095));
            default: v = int'(centre_cfg) + int'($urandom_range(0, 3000)) - 1500;
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[SAMPLE_BITS_DEF-1:0];
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic offer(sample_t s, bit typed, report_t r);
        samp.valid        <= 1'b1;
        samp.x_sample     <= s.x;
        samp.x_read_ok    <= s.x_ok;
        samp.y_sample     <= s.y;
        samp.y_read_ok    <= s.y_ok;
        samp.button_level <= s.btn_level;
        typed_due         <= typed;
        typed_rpt         <= r;
        @(posedge i_clk);
        while (!samp.ready)
            @(posedge i_clk);
    endtask

    // bursts of back-to-back requests with random gaps in between while gaps_on is set
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if (gaps_on) begin
                samp.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic quiesce();
        samp.valid <= 1'b0;
        @(posedge i_clk);
        while (reports_due.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        step_row_t             plan[$];
        sample_t               s;
        logic                  btn_now;
        logic [CFG_DATA_W-1:0] c, d, t;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= REG_CENTER;
        i_cfg_data        <= '0;
        samp.valid        <= 1'b0;
        samp.x_sample     <= '0;
        samp.x_read_ok    <= 1'b0;
        samp.y_sample     <= '0;
        samp.y_read_ok    <= 1'b0;
        samp.button_level <= 1'b1;
        typed_due         <= 1'b0;
        typed_rpt         <= '0;
        btn_now = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: centre 2048, dead band 600, threshold 100
        plan.push_back(checked_row(2048, 1, 2048, 1, 1,     0,     0, 0, 0));
        plan.push_back(checked_row(4095, 1,    0, 1, 0,  1000, -1000, 1, 1));
        plan.push_back(checked_row(   0, 1, 4095, 1, 0, -1000,  1000, 1, 0));
        plan.push_back(checked_row( 123, 0, 3999, 0, 1,     0,     0, 0, 0));  // failed reads
        plan.push_back(checked_row(2647, 1, 1449, 1, 1,     0,     0, 0, 0));  // just inside band
        plan.push_back(sample_row(2648, 1, 1448, 1, 0));   // on the band edge
        plan.push_back(sample_row(2793, 1, 1448, 1, 0));   // change equals threshold
        plan.push_back(sample_row(2795, 1, 1448, 1, 1));   // one past threshold
        plan.push_back(sample_row(2048, 0, 2048, 1, 0));
        plan.push_back(reg_row(REG_SPARE, 12'hABC));
        // divisor of zero, forced to one
        plan.push_back(reg_row(REG_THRESH, 12'd0));
        plan.push_back(reg_row(REG_CENTER, 12'd1000));
        plan.push_back(reg_row(REG_DEAD, 12'd1000));
        plan.push_back(checked_row(4095, 1,    0, 1, 1,  1000, -1000, 0, 0));
        plan.push_back(checked_row(1999, 1,    1, 1, 1,     0,     0, 0, 0));
        plan.push_back(checked_row(2000, 1, 1000, 1, 0,  1000,     0, 1, 1));
        // negative divisor: centre below dead band
        plan.push_back(reg_row(REG_CENTER, 12'd500));
        plan.push_back(sample_row(0, 1, 4095, 1, 1));
        plan.push_back(sample_row(1500, 1, 0, 0, 0));
        plan.push_back(reg_row(REG_CENTER, 12'd0));
        plan.push_back(reg_row(REG_DEAD, 12'd0));
        plan.push_back(reg_row(REG_THRESH, 12'hFFF));      // masks to 2047: nothing moves
        plan.push_back(sample_row(0, 1, 1, 1, 1));
        plan.push_back(sample_row(4095, 1, 4095, 1, 0));
        plan.push_back(reg_row(REG_CENTER, 12'hFFF));
        plan.push_back(reg_row(REG_DEAD, 12'hFFF));        // masks to 1023
        plan.push_back(reg_row(REG_THRESH, 12'd2000));
        plan.push_back(sample_row(4095, 1, 0, 1, 1));
        plan.push_back(sample_row(3072, 1, 3071, 1, 0));
        plan.push_back(reg_row(REG_CENTER, 12'd3072));
        plan.push_back(reg_row(REG_DEAD, 12'd0));
        plan.push_back(reg_row(REG_THRESH, 12'd0));
        plan.push_back(sample_row(0, 1, 4095, 1, 1));
        plan.push_back(sample_row(3072, 1, 3073, 1, 1));
        plan.push_back(reg_row(REG_CENTER, 12'd1024));
        plan.push_back(reg_row(REG_DEAD, 12'd1000));
        plan.push_back(reg_row(REG_THRESH, 12'd2000));
        plan.push_back(sample_row(2047, 1, 0, 1, 0));
        plan.push_back(sample_row(2025, 1, 23, 1, 1));

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                quiesce();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                offer(plan[i].s, plan[i].typed, plan[i].r);
                pace();
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            quiesce();
            case (ph)
                0: begin c = 12'd2048; d = 12'd600;  t = 12'd100;  end
                1: begin c = 12'd1024; d = 12'd0;    t = 12'd0;    end
                2: begin c = 12'd3072; d = 12'd1000; t = 12'd2000; end
                default: begin
                    c = $urandom_range(0, 1) ? 12'($urandom_range(1024, 3072))
                                             : 12'($urandom_range(0, 4095));
                    d = $urandom_range(0, 3) ? 12'($urandom_range(0, 1000))
                                             : 12'($urandom_range(0, 4095));
                    t = $urandom_range(0, 1) ? 12'($urandom_range(0, 300))
                                             : 12'($urandom_range(0, 4095));
                end
            endcase
            write_reg(REG_CENTER, c);
            write_reg(REG_DEAD, d);
            write_reg(REG_THRESH, t);
            gaps_on = (ph != 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2)
                    quiesce();   // hold the sender until the pipe is empty
                if ($urandom_range(0, 3) == 0)
                    btn_now = ~btn_now;
                s.x         = pick_reading();
                s.x_ok      = ($urandom_range(0, 7) != 0);
                s.y         = pick_reading();
                s.y_ok      = ($urandom_range(0, 7) != 0);
                s.btn_level = btn_now;
                offer(s, 1'b0, '0);
                pace();
            end
        end

        quiesce();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (faults == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
